// ===== rtl/sbh_pkg.sv =====
`default_nettype none

package sbh_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int LEN_POS     = 56;
	localparam int BLOCK_WORDS = BLOCK_BYTES / 4;
	localparam int HASH_WORDS  = 8;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef logic [31:0] word_t;
	typedef logic [HASH_WORDS-1:0][31:0] hash_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       message_end;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// schedule unit control, driven from the compression counter
	typedef struct packed {
		logic       load;
		logic       shift;
		logic       kw_en;
		logic [5:0] k_idx;
	} sched_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
	} round_ctl_t;

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t INIT_HASH [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t rotr(word_t x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t ssig0(word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sbh_ram.sv =====
`default_nettype none

module sbh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/sbh_sched.sv =====
`default_nettype none

module sbh_sched
	import sbh_pkg::*;
(
	input  wire logic       clk,
	input  wire sched_ctl_t ctl,
	input  wire word_t      ram_word,
	output word_t           kw
);

	// w_q[15] is the newest schedule word, w_q[0] the one fifteen back
	word_t w_q [BLOCK_WORDS];
	word_t w_new;
	word_t kw_s2;

	always_comb begin
		if (ctl.load) begin
			w_new = ram_word;
		end else begin
			w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BLOCK_WORDS-1] <= w_new;
		end
		if (ctl.kw_en) begin
			kw_s2 <= w_q[BLOCK_WORDS-1] + ROUND_K[ctl.k_idx];
		end
	end

	assign kw = kw_s2;

endmodule

`default_nettype wire

// ===== rtl/sbh_round.sv =====
`default_nettype none

module sbh_round
	import sbh_pkg::*;
(
	input  wire logic       clk,
	input  wire round_ctl_t ctl,
	input  wire hash_t      chain,
	input  wire word_t      kw,
	output hash_t           work
);

	// working variables a..h at index 0..7
	hash_t v_q;
	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	always_comb begin
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1  = v_q[7] + bsig1(v_q[4]) + ch + kw;
		t2  = bsig0(v_q[0]) + maj;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q <= chain;
		end else if (ctl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign work = v_q;

endmodule

`default_nettype wire

// ===== rtl/sha256_byte_stream_hasher.sv =====
`default_nettype none

// channel | signals                    | payload
// --------+----------------------------+---------------------------------------
// input   | in_valid / in_ready        | in_data  : data_byte, byte_valid, message_end
// output  | out_valid / out_ready      | out_data : digest_word, word_index, last_word
//
// A transfer with byte_valid set puts its byte into the 16 x 32 block RAM.
// The 64th byte of a block starts a compression (one round per cycle, the first
// sixteen schedule words fed from the RAM read port), input held off meanwhile.
// Message end: one padding byte per cycle up to the block end, one or two
// compressions, then eight digest words, one per cycle while out_ready is high.
// Reset loads the initial hash and clears all counters; no RAM clearing.

module sha256_byte_stream_hasher
	import sbh_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_FOLD,
		ST_EMIT
	} state_t;

	localparam logic [6:0] CNT_LAST = 7'd66;

	state_t     state_q;
	logic [5:0] fill_q;
	logic [63:0] bits_q;
	logic [23:0] part_q;
	logic [6:0] cnt_q;
	logic [6:0] cnt_m2;
	logic       pad_q;
	logic       seen80_q;
	logic       lenok_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;
	hash_t      chain_q;
	hash_t      work;

	logic       in_fire;
	logic       byte_we;
	logic [7:0] byte_val;
	logic [7:0] pad_byte;
	logic [7:0] len_byte;
	logic       blk_full;
	logic       ram_we;
	word_t      ram_rdata;
	word_t      kw;
	logic       out_load;
	sched_ctl_t sctl;
	round_ctl_t rctl;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// length bytes go out most significant first
	assign len_byte = bits_q[{~fill_q[2:0], 3'b111} -: 8];

	always_comb begin
		if (!seen80_q) begin
			pad_byte = PAD_BYTE;
		end else if (lenok_q && (fill_q >= 6'(LEN_POS))) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign byte_we  = (in_fire && in_data.byte_valid) || (state_q == ST_PAD);
	assign byte_val = (state_q == ST_PAD) ? pad_byte : in_data.data_byte;
	assign blk_full = byte_we && (fill_q == 6'(BLOCK_BYTES - 1));
	assign ram_we   = byte_we && (fill_q[1:0] == 2'b11);
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (byte_we) begin
			part_q <= {part_q[15:0], byte_val};
		end
	end

	// RAM is written only while bytes arrive or padding is added; read data is used only while compressing
	sbh_ram #(
		.WIDTH(32),
		.DEPTH(BLOCK_WORDS)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q[5:2]),
		.wdata({part_q, byte_val}),
		.raddr(cnt_q[3:0]),
		.rdata(ram_rdata)
	);

	// read issued at count j; schedule word j passes the RAM read register, w_q and the K+W register before round j
	assign cnt_m2 = cnt_q - 7'd2;

	always_comb begin
		sctl.load  = (cnt_q inside {[7'd1:7'd16]});
		sctl.shift = (state_q == ST_COMP) && (cnt_q inside {[7'd1:7'd64]});
		sctl.kw_en = (state_q == ST_COMP) && (cnt_q inside {[7'd2:7'd65]});
		sctl.k_idx = cnt_m2[5:0];
		rctl.load  = (state_q == ST_COMP) && (cnt_q == 7'd0);
		rctl.step  = (state_q == ST_COMP) && (cnt_q inside {[7'd3:CNT_LAST]});
	end

	sbh_sched u_sched (
		.clk     (clk),
		.ctl     (sctl),
		.ram_word(ram_rdata),
		.kw      (kw)
	);

	sbh_round u_round (
		.clk  (clk),
		.ctl  (rctl),
		.chain(chain_q),
		.kw   (kw),
		.work (work)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			bits_q      <= '0;
			cnt_q       <= '0;
			pad_q       <= 1'b0;
			seen80_q    <= 1'b0;
			lenok_q     <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= INIT_HASH[i];
			end
		end else begin
			if (byte_we) begin
				fill_q <= fill_q + 6'd1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						pad_q    <= in_data.message_end;
						seen80_q <= 1'b0;
						lenok_q  <= 1'b0;
						cnt_q    <= '0;
						if (in_data.byte_valid) begin
							bits_q <= bits_q + 64'd8;
						end
						if (blk_full) begin
							state_q <= ST_COMP;
						end else if (in_data.message_end) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (!seen80_q) begin
						seen80_q <= 1'b1;
						// length fits in this block only if the marker lands below it
						lenok_q  <= (fill_q < 6'(LEN_POS));
					end
					cnt_q <= '0;
					if (blk_full) begin
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < HASH_WORDS; i++) begin
						chain_q[i] <= chain_q[i] + work[i];
					end
					idx_q <= '0;
					if (pad_q && lenok_q) begin
						state_q <= ST_EMIT;
					end else if (pad_q) begin
						lenok_q <= 1'b1;
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						out_q.digest_word <= chain_q[idx_q];
						out_q.word_index  <= idx_q;
						out_q.last_word   <= (idx_q == 3'd7);
						idx_q             <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < HASH_WORDS; i++) begin
								chain_q[i] <= INIT_HASH[i];
							end
							bits_q  <= '0;
							pad_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_full_block_compresses: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.byte_valid && (fill_q == 6'd63) |=> state_q == ST_COMP)
		else $error("full block did not start compression");

	a_no_write_in_compress: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE) || (state_q == ST_PAD))
		else $error("block RAM written outside byte intake");

	a_last_word_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_word |-> out_data.word_index == 3'd7)
		else $error("last_word on a word other than the eighth");

	a_emit_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD) && pad_q && lenok_q |=> state_q == ST_EMIT)
		else $error("final block did not lead to digest output");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/sha256_digest_checker.sv =====
`timescale 1ns / 1ps

module sha256_digest_checker
	import sbh_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_ready,
	input  wire in_item_t  in_data,
	input  wire logic      out_valid,
	input  wire logic      out_ready,
	input  wire out_item_t out_data,
	output int             errors,
	output int             pending,
	output int             words_seen
);

	localparam int unsigned BLK_LEN  = 64;
	localparam int unsigned LEN_AT   = 56;
	localparam logic [7:0]  END_MARK = 8'h80;

	localparam logic [31:0] K256 [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] H0 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [31:0]  hv [8];
	logic [7:0]   blk [64];
	int unsigned  blk_fill;
	logic [63:0]  bit_len;
	out_item_t    digest_q [$];
	int           err_cnt;
	int           word_cnt;

	function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic clear_hash();
		for (int i = 0; i < 8; i++)
			hv[i] = H0[i];
		blk_fill = 0;
		bit_len  = '0;
	endtask

	task automatic run_rounds();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		for (int i = 0; i < 8; i++)
			v[i] = hv[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K256[i] + w[i];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hv[i] = hv[i] + v[i];
	endtask

	// absorbs one input transfer; a message end queues the eight digest words
	task automatic hash_item(in_item_t it);
		int unsigned p;
		out_item_t   w;
		if (it.byte_valid) begin
			blk[blk_fill] = it.data_byte;
			blk_fill++;
			bit_len += 64'd8;
			if (blk_fill == BLK_LEN) begin
				run_rounds();
				blk_fill = 0;
			end
		end
		if (it.message_end) begin
			p = blk_fill;
			blk[p] = END_MARK;
			p++;
			// no room left for the length field: spill into an extra block
			if (p > LEN_AT) begin
				while (p < BLK_LEN) begin
					blk[p] = 8'h00;
					p++;
				end
				run_rounds();
				p = 0;
			end
			while (p < LEN_AT) begin
				blk[p] = 8'h00;
				p++;
			end
			for (int i = 0; i < 8; i++)
				blk[LEN_AT + i] = bit_len[63 - 8*i -: 8];
			run_rounds();
			for (int i = 0; i < 8; i++) begin
				w.digest_word = hv[i];
				w.word_index  = 3'(i);
				w.last_word   = (i == 7);
				digest_q = {digest_q, w};
			end
			clear_hash();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_w;
		if (!arst_n) begin
			clear_hash();
			digest_q.delete();
			err_cnt  = 0;
			word_cnt = 0;
			pending    <= 0;
			errors     <= 0;
			words_seen <= 0;
		end else begin
			if (in_valid && in_ready)
				hash_item(in_data);
			if (out_valid && out_ready) begin
				word_cnt++;
				if (digest_q.size() == 0) begin
					$error("unexpected digest transfer: word %h index %0d",
						out_data.digest_word, out_data.word_index);
					err_cnt++;
				end else begin
					exp_w = digest_q.pop_front();
					if (out_data.digest_word !== exp_w.digest_word) begin
						$error("digest_word: expected %h, got %h",
							exp_w.digest_word, out_data.digest_word);
						err_cnt++;
					end
					if (out_data.word_index !== exp_w.word_index) begin
						$error("word_index: expected %0d, got %0d",
							exp_w.word_index, out_data.word_index);
						err_cnt++;
					end
					if (out_data.last_word !== exp_w.last_word) begin
						$error("last_word: expected %b, got %b",
							exp_w.last_word, out_data.last_word);
						err_cnt++;
					end
				end
			end
			pending    <= digest_q.size();
			errors     <= err_cnt;
			words_seen <= word_cnt;
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench
	import sbh_pkg::*;
();

	localparam int RANDOM_ITEMS = 460;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 400000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	int errors;
	int pending;
	int words_seen;

	int in_gap_pct;
	int out_stall_pct;
	int n_messages;
	int n_bytes;
	int n_idle;
	int n_items;

	sha256_byte_stream_hasher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	sha256_digest_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.errors     (errors),
		.pending    (pending),
		.words_seen (words_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	function automatic in_item_t pack_item(logic [7:0] b, logic bv, logic me);
		in_item_t it;
		it.data_byte   = b;
		it.byte_valid  = bv;
		it.message_end = me;
		return it;
	endfunction

	// returns at the edge where the transfer happened; valid stays up until a gap or a drain follows
	task automatic send_item(in_item_t it);
		if ($urandom_range(99) < in_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_gap_pct);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		if (it.byte_valid)
			n_bytes++;
		if (it.message_end)
			n_messages++;
		if (!it.byte_valid && !it.message_end)
			n_idle++;
		n_items++;
	endtask

	task automatic send_message(int unsigned len);
		bit end_alone;
		end_alone = (len == 0) || ($urandom_range(1) == 0);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				send_item(pack_item(8'($urandom_range(255)), 1'b0, 1'b0));
			send_item(pack_item(8'($urandom_range(255)), 1'b1,
				!end_alone && (i == len - 1)));
		end
		if (end_alone)
			send_item(pack_item(8'($urandom_range(255)), 1'b0, 1'b1));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int unsigned len;
		int          goal;
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		out_ready     = 1'b0;
		in_gap_pct    = 17;
		out_stall_pct = 60;
		n_messages    = 0;
		n_bytes       = 0;
		n_idle        = 0;
		n_items       = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, idle step, byte with end, "abc", two bytes + idle step + end without a byte, byte with end
		send_item(pack_item(8'hA5, 1'b0, 1'b1));
		send_item(pack_item(8'h5A, 1'b0, 1'b0));
		send_item(pack_item(8'h00, 1'b1, 1'b1));
		send_item(pack_item(8'h61, 1'b1, 1'b0));
		send_item(pack_item(8'h62, 1'b1, 1'b0));
		send_item(pack_item(8'h63, 1'b1, 1'b1));
		send_item(pack_item(8'hFF, 1'b1, 1'b0));
		send_item(pack_item(8'h00, 1'b1, 1'b0));
		send_item(pack_item(8'hFF, 1'b0, 1'b0));
		send_item(pack_item(8'h00, 1'b0, 1'b1));
		send_item(pack_item(8'hFF, 1'b1, 1'b1));

		goal = n_items;
		for (int ph = 0; ph < 3; ph++) begin
			if (ph > 0) begin
				wait_drained();
				in_gap_pct    <= (ph == 1) ? 60 : 0;
				out_stall_pct <= (ph == 1) ? 17 : 0;
			end
			goal += RANDOM_ITEMS / 3;
			while (n_items < goal) begin
				// favor lengths around the padding and block boundaries
				case ($urandom_range(9))
					0: len = $urandom_range(57, 54);
					1: len = $urandom_range(66, 62);
					2: len = $urandom_range(121, 118);
					default: len = $urandom_range(24, 0);
				endcase
				// keep the phase close to its item budget
				if (len > unsigned'(goal - n_items))
					len = unsigned'(goal - n_items);
				send_message(len);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d messages, %0d message bytes, %0d idle steps",
			n_messages, n_bytes, n_idle);
		$display("%0d digest words compared, %0d errors", words_seen, errors);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles, %0d digest words still due", CYCLE_LIMIT, pending);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
